>>> design/sample_table_poke_and_centroid_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sample table block
// Property wrappers used by the RTL; they expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef SAMPLE_TABLE_POKE_AND_CENTROID_MACROS_SVH
`define SAMPLE_TABLE_POKE_AND_CENTROID_MACROS_SVH

`ifndef SYNTHESIS

// condition must never hold
`define STPC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define STPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define STPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define STPC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`define STPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define STPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> design/stpc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sample table package
// Shared widths, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package stpc_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 4096;

    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 17;
    localparam int SAMPLE_W = 16;
    localparam int SPAN_W   = 13;
    localparam int LENGTH_W = 13;
    localparam int CENT_W   = 32;
    localparam int LEN_W    = 17;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    localparam logic [LENGTH_W-1:0] LENGTH_RESET = 13'd4096;

    localparam logic [KIND_W-1:0] KIND_ARM        = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCESS     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ARM_ACCESS = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CENTROID   = 2'd3;

    localparam logic RES_SAMPLE   = 1'b0;
    localparam logic RES_CENTROID = 1'b1;

    localparam logic [CENT_W-1:0] CENT_MAX = 32'h7fff_ffff;
    localparam logic [CENT_W-1:0] CENT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic clr_en;
        logic take;
        logic wr_pending;
        logic rd_access;
        logic sum_run;
        logic div_start;
        logic div_step;
        logic load_sample;
        logic load_centroid;
    } stpc_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic armed;
        logic span_bad;
        logic sum_done;
        logic div_done;
        logic out_free;
    } stpc_status_t;

endpackage

>>> design/stpc_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module stpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/stpc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sample table controller
// Sequences clearing, table accesses, centroid summing and division.
// ---------------------------------------------------------------------------
module stpc_ctrl
    import stpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic [KIND_W-1:0] s_tuser,
    output logic              s_tready,
    input  stpc_status_t      status,
    output stpc_cmd_t         cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;
    localparam logic [2:0] ST_DIVLD = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.take = 1'b1;
                    unique case (s_tuser)
                        KIND_ARM:        state_next = ST_IDLE;
                        KIND_ACCESS:     state_next = ST_EXEC;
                        KIND_ARM_ACCESS: state_next = ST_EXEC;
                        KIND_CENTROID:   state_next = status.span_bad ? ST_IDLE : ST_SUM;
                    endcase
                end
            end
            ST_EXEC:
            begin
                if (status.armed)
                begin
                    cmd.wr_pending = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.rd_access = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                if (status.out_free)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                cmd.sum_run = 1'b1;
                if (status.sum_done)
                begin
                    state_next = ST_DIVLD;
                end
            end
            ST_DIVLD:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_centroid = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/stpc_dp.sv
`timescale 1ns / 1ps
`include "sample_table_poke_and_centroid_macros.svh"
// ---------------------------------------------------------------------------
// Sample table datapath
// Table memory, index clamp, weighted sums, serial divider and result register.
// ---------------------------------------------------------------------------
module stpc_dp
    import stpc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [LENGTH_W-1:0]   cfg_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    input  stpc_cmd_t             cmd,
    output stpc_status_t          status
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int PROD_W = ADDR_W + 17;
    localparam int TOP_W  = 2 * ADDR_W + 17;
    localparam int BOT_W  = ADDR_W + 17;
    localparam int NUM_W  = TOP_W + 8;
    localparam int DCNT_W = $clog2(NUM_W + 1);
    localparam int QX_W   = (NUM_W > 33) ? NUM_W : 33;

    // item fields
    logic signed [INDEX_W-1:0]  in_index;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic        [SPAN_W-1:0]   in_span;

    assign in_index  = s_tdata[16:0];
    assign in_sample = s_tdata[32:17];
    assign in_span   = s_tdata[45:33];

    // length register and clamps
    logic [LENGTH_W-1:0] length_reg;
    logic [LENGTH_W-1:0] length_next;
    logic [LEN_W-1:0]    used_len;
    logic [LEN_W-1:0]    clamp_idx;

    always_comb
    begin
        length_next = cfg_valid ? cfg_data : length_reg;
    end

    always_comb
    begin
        priority if (length_reg == '0)
        begin
            used_len = LEN_W'(1);
        end
        else if (LEN_W'(length_reg) > LEN_W'(TABLE_DEPTH))
        begin
            used_len = LEN_W'(TABLE_DEPTH);
        end
        else
        begin
            used_len = LEN_W'(length_reg);
        end
    end

    always_comb
    begin
        priority if (in_index[INDEX_W-1])
        begin
            clamp_idx = '0;
        end
        else if (LEN_W'(in_index[INDEX_W-2:0]) >= used_len)
        begin
            clamp_idx = used_len - LEN_W'(1);
        end
        else
        begin
            clamp_idx = LEN_W'(in_index[INDEX_W-2:0]);
        end
    end

    // item state
    logic                       armed_reg;
    logic                       armed_next;
    logic signed [SAMPLE_W-1:0] pending_reg;
    logic signed [SAMPLE_W-1:0] pending_next;
    logic [ADDR_W-1:0]          addr_reg;
    logic [ADDR_W-1:0]          addr_next;
    logic [CNT_W-1:0]           span_reg;
    logic [CNT_W-1:0]           span_next;
    logic [ADDR_W-1:0]          clr_addr_reg;
    logic [ADDR_W-1:0]          clr_addr_next;
    logic                       arming;

    assign arming = cmd.take && (s_tuser == KIND_ARM || s_tuser == KIND_ARM_ACCESS);

    always_comb
    begin
        armed_next    = armed_reg;
        pending_next  = pending_reg;
        addr_next     = addr_reg;
        span_next     = span_reg;
        clr_addr_next = clr_addr_reg;
        if (arming)
        begin
            armed_next   = 1'b1;
            pending_next = in_sample;
        end
        if (cmd.wr_pending)
        begin
            armed_next = 1'b0;
        end
        if (cmd.take)
        begin
            addr_next = clamp_idx[ADDR_W-1:0];
            span_next = CNT_W'(in_span);
        end
        if (cmd.clr_en)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end
    end

    // table memory
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [SAMPLE_W-1:0]        ram_wdata;
    logic                       ram_re;
    logic [ADDR_W-1:0]          ram_raddr;
    logic signed [SAMPLE_W-1:0] ram_rdata;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic                       sum_issue;

    assign sum_issue = cmd.sum_run && (cnt_reg != span_reg);
    assign ram_we    = cmd.clr_en || cmd.wr_pending;
    assign ram_waddr = cmd.clr_en ? clr_addr_reg : addr_reg;
    assign ram_wdata = cmd.clr_en ? '0 : pending_reg;
    assign ram_re    = cmd.rd_access || sum_issue;
    assign ram_raddr = cmd.rd_access ? addr_reg : cnt_reg[ADDR_W-1:0];

    stpc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // weighted sum pipeline
    logic                       rd_v_reg;
    logic                       rd_v_next;
    logic [ADDR_W-1:0]          rd_i_reg;
    logic [ADDR_W-1:0]          rd_i_next;
    logic                       mul_v_reg;
    logic                       mul_v_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [SAMPLE_W-1:0] smp_reg;
    logic signed [SAMPLE_W-1:0] smp_next;
    logic signed [TOP_W-1:0]    top_reg;
    logic signed [TOP_W-1:0]    top_next;
    logic signed [BOT_W-1:0]    bot_reg;
    logic signed [BOT_W-1:0]    bot_next;

    always_comb
    begin
        cnt_next   = cnt_reg;
        rd_v_next  = sum_issue;
        rd_i_next  = rd_i_reg;
        mul_v_next = rd_v_reg;
        prod_next  = prod_reg;
        smp_next   = smp_reg;
        top_next   = top_reg;
        bot_next   = bot_reg;
        if (sum_issue)
        begin
            cnt_next  = cnt_reg + 1'b1;
            rd_i_next = cnt_reg[ADDR_W-1:0];
        end
        if (rd_v_reg)
        begin
            prod_next = PROD_W'($signed({1'b0, rd_i_reg})) * PROD_W'(ram_rdata);
            smp_next  = ram_rdata;
        end
        if (mul_v_reg)
        begin
            top_next = top_reg + TOP_W'(prod_reg);
            bot_next = bot_reg + BOT_W'(smp_reg);
        end
        if (cmd.take)
        begin
            cnt_next = '0;
            top_next = '0;
            bot_next = '0;
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [TOP_W-1:0]  top_mag;
    logic [BOT_W-1:0]  bot_mag;
    logic [BOT_W-1:0]  rem_reg;
    logic [BOT_W-1:0]  rem_next;
    logic [BOT_W-1:0]  den_reg;
    logic [BOT_W-1:0]  den_next;
    logic [NUM_W-1:0]  qn_reg;
    logic [NUM_W-1:0]  qn_next;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [DCNT_W-1:0] div_cnt_next;
    logic              neg_reg;
    logic              neg_next;
    logic              zero_reg;
    logic              zero_next;
    logic [BOT_W:0]    trial;
    logic [BOT_W:0]    trial_diff;
    logic              trial_ge;

    assign top_mag    = top_reg[TOP_W-1] ? (~top_reg + 1'b1) : top_reg;
    assign bot_mag    = bot_reg[BOT_W-1] ? (~bot_reg + 1'b1) : bot_reg;
    assign trial      = {rem_reg, qn_reg[NUM_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign trial_ge   = (trial >= {1'b0, den_reg});

    always_comb
    begin
        rem_next     = rem_reg;
        den_next     = den_reg;
        qn_next      = qn_reg;
        div_cnt_next = div_cnt_reg;
        neg_next     = neg_reg;
        zero_next    = zero_reg;
        if (cmd.div_start)
        begin
            rem_next     = '0;
            den_next     = bot_mag;
            qn_next      = {top_mag, 8'd0};
            div_cnt_next = '0;
            neg_next     = top_reg[TOP_W-1] ^ bot_reg[BOT_W-1];
            zero_next    = (bot_reg == '0);
        end
        else if (cmd.div_step)
        begin
            rem_next     = trial_ge ? trial_diff[BOT_W-1:0] : trial[BOT_W-1:0];
            qn_next      = {qn_reg[NUM_W-2:0], trial_ge};
            div_cnt_next = div_cnt_reg + 1'b1;
        end
    end

    // saturate
    logic [QX_W-1:0]   qx;
    logic              pos_ovf;
    logic              neg_ovf;
    logic [CENT_W-1:0] cent_val;

    assign qx      = QX_W'(qn_reg);
    assign pos_ovf = |qx[QX_W-1:31];
    assign neg_ovf = (|qx[QX_W-1:32]) || (qx[31] && (|qx[30:0]));

    always_comb
    begin
        priority if (zero_reg)
        begin
            cent_val = '0;
        end
        else if (neg_reg)
        begin
            cent_val = neg_ovf ? CENT_MIN : (~qx[31:0] + 1'b1);
        end
        else
        begin
            cent_val = pos_ovf ? CENT_MAX : qx[31:0];
        end
    end

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_kind_reg;
    logic                out_kind_next;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic [SAMPLE_W-1:0] out_sample_next;
    logic [CENT_W-1:0]   out_cent_reg;
    logic [CENT_W-1:0]   out_cent_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_sample_next = out_sample_reg;
        out_cent_next   = out_cent_reg;
        if (cmd.load_sample)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = RES_SAMPLE;
            out_sample_next = ram_rdata;
            out_cent_next   = '0;
        end
        else if (cmd.load_centroid)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = RES_CENTROID;
            out_sample_next = '0;
            out_cent_next   = cent_val;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_cent_reg, out_sample_reg};

    // status
    assign status.clear_last = (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1));
    assign status.armed      = armed_reg;
    assign status.span_bad   = (LEN_W'(in_span) > used_len);
    assign status.sum_done   = (cnt_reg == span_reg) && !rd_v_reg && !mul_v_reg;
    assign status.div_done   = (div_cnt_reg == DCNT_W'(NUM_W - 1));
    assign status.out_free   = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= LENGTH_RESET;
            armed_reg     <= 1'b0;
            pending_reg   <= '0;
            clr_addr_reg  <= '0;
            cnt_reg       <= '0;
            rd_v_reg      <= 1'b0;
            mul_v_reg     <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg    <= length_next;
            armed_reg     <= armed_next;
            pending_reg   <= pending_next;
            clr_addr_reg  <= clr_addr_next;
            cnt_reg       <= cnt_next;
            rd_v_reg      <= rd_v_next;
            mul_v_reg     <= mul_v_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        span_reg       <= span_next;
        rd_i_reg       <= rd_i_next;
        prod_reg       <= prod_next;
        smp_reg        <= smp_next;
        top_reg        <= top_next;
        bot_reg        <= bot_next;
        rem_reg        <= rem_next;
        den_reg        <= den_next;
        qn_reg         <= qn_next;
        neg_reg        <= neg_next;
        zero_reg       <= zero_next;
        out_kind_reg   <= out_kind_next;
        out_sample_reg <= out_sample_next;
        out_cent_reg   <= out_cent_next;
    end

    `STPC_ASSERT_NEVER(a_clear_excl, clk, rst_n,
        cmd.clr_en && (cmd.wr_pending || cmd.rd_access || cmd.sum_run), "table clear overlaps access")
    `STPC_ASSERT_IMPLY(a_load_free, clk, rst_n,
        cmd.load_sample || cmd.load_centroid, !out_valid_reg || m_tready, "result overwritten")
    `STPC_ASSERT_NEXT(a_disarm, clk, rst_n,
        cmd.wr_pending, !armed_reg, "write left armed")
    `STPC_ASSERT_IMPLY(a_div_range, clk, rst_n,
        cmd.div_step, div_cnt_reg < DCNT_W'(NUM_W), "divider overrun")

endmodule

>>> design/sample_table_poke_and_centroid.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sample table with armed write and centroid query
// Stores signed Q1.15 samples; arms and pokes values, reads them back and
// returns the weighted-index centroid of the leading entries.
// ---------------------------------------------------------------------------
// After reset the block zeroes the table and takes no item meanwhile; length
// writes are taken at any time. An arm item only latches its sample, an armed
// access writes the latched sample to the table, and an unarmed access reads
// the table and waits for the result register. A centroid query streams span
// table reads through the multiply-accumulate pipeline, then yields one quotient
// bit per cycle in the serial divider (2*log2(TABLE_DEPTH) + 25 bits, 49 at 4096 entries).
module sample_table_poke_and_centroid
    import stpc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LENGTH_W-1:0]   cfg_data,   // table_length
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,    // index, sample_in, span, zero pad
    input  logic [KIND_W-1:0]     s_tuser,    // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,    // sample_out, centroid
    output logic                  m_tuser     // result_kind
);

    stpc_cmd_t    cmd;
    stpc_status_t status;
    logic         cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    stpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stpc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_we),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sample table block testbench
// Drives arm, access, arm-and-access and centroid items through the slave
// stream with random gaps, models the table and the armed value alongside the
// block, and checks every item on the master stream against the model.
// ---------------------------------------------------------------------------
module tb_top;
    import stpc_pkg::*;

    localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_LIMIT = 50_000;
    localparam int SETTLE      = 20;
    localparam int PHASE_ITEMS = 153;

    typedef struct {
        logic              kind;
        logic [SAMPLE_W-1:0] sample;
        logic [CENT_W-1:0]   cent;
    } table_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [LENGTH_W-1:0]   cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]     s_tuser = KIND_ARM;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    logic signed [SAMPLE_W-1:0] sample_mem [DEPTH];
    logic                       armed_flag;
    logic signed [SAMPLE_W-1:0] armed_value;
    logic [LENGTH_W-1:0]        length_reg;

    table_result_t expected_results [$];
    int    errors = 0;
    int    cycles = 0;
    bit    steady = 1'b0;

    sample_table_poke_and_centroid DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        if (errors < 30)
            $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic int used_length();
        if (length_reg == 0)
            return 1;
        if (length_reg > DEPTH)
            return DEPTH;
        return int'(length_reg);
    endfunction

    function automatic int clamped_slot(logic signed [INDEX_W-1:0] idx);
        int x;
        x = int'(idx);
        if (x >= used_length())
            x = used_length() - 1;
        if (x < 0)
            x = 0;
        return x;
    endfunction

    function automatic void access_slot(logic signed [INDEX_W-1:0] idx);
        table_result_t r;
        int slot;
        slot = clamped_slot(idx);
        if (armed_flag)
        begin
            sample_mem[slot[ADDR_W-1:0]] = armed_value;
            armed_flag = 1'b0;
        end
        else
        begin
            r.kind = RES_SAMPLE;
            r.sample = sample_mem[slot[ADDR_W-1:0]];
            r.cent = '0;
            expected_results.push_back(r);
        end
    endfunction

    function automatic void centroid_of_span(logic [SPAN_W-1:0] span);
        table_result_t r;
        longint top;
        longint bottom;
        longint q;
        top = 0;
        bottom = 0;
        q = 0;
        if (span > used_length())
            return;
        for (int i = 0; i < span; i++)
        begin
            top += longint'(i) * longint'(sample_mem[i[ADDR_W-1:0]]);
            bottom += longint'(sample_mem[i[ADDR_W-1:0]]);
        end
        if (bottom != 0)
        begin
            q = (top * 256) / bottom;
            if (q > 64'sd2147483647)
                q = 64'sd2147483647;
            if (q < -64'sd2147483648)
                q = -64'sd2147483648;
        end
        r.kind = RES_CENTROID;
        r.sample = '0;
        r.cent = q[CENT_W-1:0];
        expected_results.push_back(r);
    endfunction

    function automatic void apply_item(logic [KIND_W-1:0] kind, logic signed [INDEX_W-1:0] idx,
                                       logic signed [SAMPLE_W-1:0] smp, logic [SPAN_W-1:0] span);
        case (kind)
            KIND_ARM:
            begin
                armed_value = smp;
                armed_flag = 1'b1;
            end
            KIND_ACCESS:
                access_slot(idx);
            KIND_ARM_ACCESS:
            begin
                armed_value = smp;
                armed_flag = 1'b1;
                access_slot(idx);
            end
            default:
                centroid_of_span(span);
        endcase
    endfunction

    task automatic send_item(logic [KIND_W-1:0] kind, logic signed [INDEX_W-1:0] idx,
                             logic signed [SAMPLE_W-1:0] smp, logic [SPAN_W-1:0] span);
        while (!steady && $urandom_range(99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {2'b00, span, smp, idx};
        do
            @(posedge clk);
        while (!s_tready);
        apply_item(kind, idx, smp, span);
    endtask

    task automatic wait_drained();
        int spins;
        spins = 0;
        s_tvalid <= 1'b0;
        while (expected_results.size() > 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        if (expected_results.size() > 0)
        begin
            report_mismatch("results missing", 0, longint'(expected_results.size()));
            expected_results.delete();
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_length(logic [LENGTH_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        length_reg = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, kind", longint'(m_tuser), -1);
            else
            begin
                want = expected_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("result_kind", longint'(m_tuser), longint'(want.kind));
                if (m_tdata[15:0] !== want.sample)
                    report_mismatch("sample_out", longint'($signed(m_tdata[15:0])),
                                    longint'($signed(want.sample)));
                if (m_tdata[47:16] !== want.cent)
                    report_mismatch("centroid", longint'($signed(m_tdata[47:16])),
                                    longint'($signed(want.cent)));
            end
        end
        m_tready <= steady || ($urandom_range(99) >= 26);
    end

    task automatic test_read_extremes();
        send_item(KIND_ACCESS, -17'sd65536, 16'sd0, 13'd0);
        send_item(KIND_ACCESS, 17'sd65535, 16'sd0, 13'd0);
        send_item(KIND_CENTROID, 17'sd0, 16'sd0, 13'd0);
    endtask

    task automatic test_armed_writes();
        send_item(KIND_ARM, 17'sd0, 16'sd32767, 13'd0);
        send_item(KIND_ACCESS, 17'sd4000, 16'sd0, 13'd0);
        send_item(KIND_ARM_ACCESS, 17'sd0, -16'sd32768, 13'd0);
        send_item(KIND_ACCESS, 17'sd4000, 16'sd0, 13'd0);
        send_item(KIND_ACCESS, 17'sd0, 16'sd0, 13'd0);
        send_item(KIND_ARM, 17'sd0, 16'sd123, 13'd0);
        send_item(KIND_ARM_ACCESS, 17'sd7, 16'sd456, 13'd0);
        send_item(KIND_ACCESS, 17'sd7, 16'sd0, 13'd0);
    endtask

    task automatic test_centroid_limits();
        send_item(KIND_CENTROID, 17'sd0, 16'sd0, 13'd4096);
        send_item(KIND_CENTROID, 17'sd0, 16'sd0, 13'd4097);
        send_item(KIND_CENTROID, 17'sd0, 16'sd0, 13'd8191);
        send_item(KIND_ARM_ACCESS, 17'sd0, -16'sd32767, 13'd0);
        send_item(KIND_CENTROID, 17'sd0, 16'sd0, 13'd4096);
        send_item(KIND_ARM_ACCESS, 17'sd0, -16'sd32766, 13'd0);
        send_item(KIND_CENTROID, 17'sd0, 16'sd0, 13'd4096);
        send_item(KIND_ARM_ACCESS, 17'sd0, 16'sd0, 13'd0);
        send_item(KIND_ARM_ACCESS, 17'sd4000, 16'sd0, 13'd0);
        send_item(KIND_ARM_ACCESS, 17'sd7, 16'sd0, 13'd0);
    endtask

    task automatic test_length_limits();
        wait_drained();
        write_length(13'd0);
        send_item(KIND_ACCESS, 17'sd5, 16'sd0, 13'd0);
        send_item(KIND_CENTROID, 17'sd0, 16'sd0, 13'd1);
        send_item(KIND_CENTROID, 17'sd0, 16'sd0, 13'd2);
        wait_drained();
        write_length(13'd8191);
        send_item(KIND_ACCESS, 17'sd65535, 16'sd0, 13'd0);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return 16'h7fff;
        if (r < 12)
            return 16'h8000;
        if (r < 18)
            return 16'hffff;
        if (r < 22)
            return 16'h0001;
        if (r < 26)
            return 16'h0000;
        return SAMPLE_W'($urandom);
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        int r;
        int len;
        r = $urandom_range(99);
        len = used_length();
        if (r < 60)
            return INDEX_W'($urandom_range(0, len - 1));
        if (r < 75)
            return INDEX_W'((len > 2) ? $urandom_range(len - 2, len + 1) : $urandom_range(0, 3));
        return INDEX_W'($urandom);
    endfunction

    function automatic logic [SPAN_W-1:0] pick_span();
        int r;
        int len;
        r = $urandom_range(99);
        len = used_length();
        if (r < 2)
            return SPAN_W'($urandom_range(0, 8191));
        if (r < 22 && len <= 400)
            return SPAN_W'($urandom_range((len > 2) ? len - 2 : 0, len + 2));
        return SPAN_W'($urandom_range(0, (len < 48) ? len : 48));
    endfunction

    task automatic test_random_traffic();
        logic [LENGTH_W-1:0] lengths [10];
        int sent;
        int r;
        lengths = '{13'd1, 13'd2, 13'd7, 13'd40, 13'd0, 13'd333, 13'd4096, 13'd8191,
                    13'd4095, 13'd0};
        lengths[9] = LENGTH_W'($urandom_range(3, 64));
        for (int p = 0; p < 10; p++)
        begin
            wait_drained();
            write_length(lengths[p]);
            steady = (p == 3);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                r = $urandom_range(99);
                if (r < 25)
                begin
                    send_item(KIND_ARM, pick_index(), pick_sample(), pick_span());
                    send_item(KIND_ACCESS, pick_index(), pick_sample(), pick_span());
                    sent += 2;
                end
                else
                begin
                    if (r < 45)
                        send_item(KIND_ARM_ACCESS, pick_index(), pick_sample(), pick_span());
                    else if (r < 75)
                        send_item(KIND_ACCESS, pick_index(), pick_sample(), pick_span());
                    else if (r < 92)
                        send_item(KIND_CENTROID, pick_index(), pick_sample(), pick_span());
                    else
                        send_item(KIND_ARM, pick_index(), pick_sample(), pick_span());
                    sent++;
                end
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            sample_mem[i[ADDR_W-1:0]] = '0;
        armed_flag = 1'b0;
        armed_value = '0;
        length_reg = LENGTH_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_read_extremes();
        test_armed_writes();
        test_centroid_limits();
        test_length_limits();
        test_random_traffic();
        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
